@@ src/vnorm_pkg.sv @@
// Shared types and constants for the vector normalization core.
// No dependencies.
`default_nettype none
package vnorm_pkg;
  localparam int unsigned Depth    = 64;
  localparam int unsigned FracBits = 16;
  localparam int unsigned AddrW    = $clog2(Depth);
  localparam int unsigned CntW     = $clog2(Depth + 1);

  typedef enum logic [2:0] {
    MODE_SUM  = 3'd0,
    MODE_MAX  = 3'd1,
    MODE_MIN  = 3'd2,
    MODE_RNG  = 3'd3,
    MODE_ZSC  = 3'd4
  } mode_e;

  typedef enum logic [3:0] {
    ST_LOAD, ST_RED, ST_MEAN, ST_VAR, ST_VDIV, ST_SQRT, ST_PICK,
    ST_RD, ST_DIV, ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic red_clr;   // clear reduction accumulators
    logic red_step;  // fold store read data
    logic mean_go;   // start mean division
    logic var_step;  // fold squared deviation
    logic vdiv_go;   // start variance division
    logic sqrt_go;   // start square root
    logic pick;      // latch divisor and base
    logic div_go;    // start sample division
    logic rd_en;     // issue store read
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_busy;
    logic sqrt_busy;
    logic active;
  } dp_sts_t;
endpackage
`default_nettype wire

@@ src/vnorm_ctrl.sv @@
// Controller state machine of the vector normalization core.
// Depends on vnorm_pkg.
`default_nettype none
module vnorm_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_fire_i,
  input  wire logic                   in_last_i,
  input  wire logic [2:0]             mode_i,
  input  wire logic [vnorm_pkg::CntW-1:0] fill_i,
  input  wire vnorm_pkg::dp_sts_t     sts_i,
  input  wire logic                   out_free_i,
  output vnorm_pkg::dp_cmd_t          cmd_o,
  output logic [vnorm_pkg::AddrW-1:0] raddr_o,
  output logic                        load_o,
  output logic                        emit_o,
  output logic                        emit_last_o,
  output logic                        done_o
);
  vnorm_pkg::state_e st_q, st_d;
  logic [vnorm_pkg::CntW-1:0] idx_q, idx_d;
  logic rdv_q;
  logic [vnorm_pkg::CntW-1:0] last_idx;

  assign last_idx = fill_i - 1'b1;
  assign raddr_o  = idx_q[vnorm_pkg::AddrW-1:0];

  // next state
  always_comb begin
    st_d  = st_q;
    idx_d = idx_q;
    unique case (st_q)
      vnorm_pkg::ST_LOAD: begin
        if (in_fire_i && in_last_i) begin
          st_d = vnorm_pkg::ST_RED; idx_d = '0;
        end
      end
      vnorm_pkg::ST_RED: begin
        if (idx_q == fill_i) st_d = vnorm_pkg::ST_MEAN;
        else idx_d = idx_q + 1'b1;
      end
      vnorm_pkg::ST_MEAN: begin
        if (rdv_q && !sts_i.div_busy) begin
          idx_d = '0;
          st_d = (mode_i == vnorm_pkg::MODE_ZSC && fill_i >= 2) ?
                 vnorm_pkg::ST_VAR : vnorm_pkg::ST_PICK;
        end
      end
      vnorm_pkg::ST_VAR: begin
        if (idx_q == fill_i) st_d = vnorm_pkg::ST_VDIV;
        else idx_d = idx_q + 1'b1;
      end
      vnorm_pkg::ST_VDIV:
        if (rdv_q && !sts_i.div_busy) st_d = vnorm_pkg::ST_SQRT;
      vnorm_pkg::ST_SQRT:
        if (rdv_q && !sts_i.sqrt_busy) st_d = vnorm_pkg::ST_PICK;
      vnorm_pkg::ST_PICK: begin
        st_d = vnorm_pkg::ST_RD; idx_d = '0;
      end
      vnorm_pkg::ST_RD: st_d = vnorm_pkg::ST_DIV;
      vnorm_pkg::ST_DIV:
        if (!sts_i.active || (rdv_q && !sts_i.div_busy)) st_d = vnorm_pkg::ST_OUT;
      vnorm_pkg::ST_OUT: begin
        if (out_free_i) begin
          if (idx_q == last_idx) st_d = vnorm_pkg::ST_LOAD;
          else begin
            st_d = vnorm_pkg::ST_RD; idx_d = idx_q + 1'b1;
          end
        end
      end
      default: st_d = vnorm_pkg::ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    load_o      = (st_q == vnorm_pkg::ST_LOAD);
    emit_o      = 1'b0;
    emit_last_o = (idx_q == last_idx);
    done_o      = 1'b0;
    unique case (st_q)
      vnorm_pkg::ST_LOAD: cmd_o.red_clr = in_fire_i && in_last_i;
      vnorm_pkg::ST_RED: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.red_step = (idx_q != '0);
      end
      vnorm_pkg::ST_MEAN: cmd_o.mean_go = !rdv_q;
      vnorm_pkg::ST_VAR: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.var_step = (idx_q != '0);
      end
      vnorm_pkg::ST_VDIV: cmd_o.vdiv_go = !rdv_q;
      vnorm_pkg::ST_SQRT: cmd_o.sqrt_go = !rdv_q;
      vnorm_pkg::ST_PICK: cmd_o.pick = 1'b1;
      vnorm_pkg::ST_RD:   cmd_o.rd_en = 1'b1;
      vnorm_pkg::ST_DIV:  cmd_o.div_go = !rdv_q && sts_i.active;
      vnorm_pkg::ST_OUT: begin
        emit_o = out_free_i;
        done_o = out_free_i && (idx_q == last_idx);
      end
      default: ;
    endcase
  end

  // hold state; rdv_q marks that a unit was started in this state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= vnorm_pkg::ST_LOAD;
      idx_q <= '0;
      rdv_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      idx_q <= idx_d;
      rdv_q <= (st_d == st_q) && (st_q == vnorm_pkg::ST_MEAN || st_q == vnorm_pkg::ST_VDIV ||
               st_q == vnorm_pkg::ST_SQRT || st_q == vnorm_pkg::ST_DIV);
    end
  end
endmodule
`default_nettype wire

@@ src/vnorm_div.sv @@
// Iterative restoring divider, one quotient bit per cycle, 96/64 bits.
// No dependencies.
`default_nettype none
module vnorm_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [95:0] num_i,
  input  wire logic [63:0] den_i,
  output logic             busy_o,
  output logic [95:0]      quo_o
);
  logic [95:0] q_q;
  logic [63:0] r_q;
  logic [63:0] d_q;
  logic [6:0]  cnt_q;
  logic [64:0] r_sh;
  logic        ge;

  assign r_sh  = {r_q, q_q[95]};
  assign ge    = r_sh >= {1'b0, d_q};
  assign busy_o = (cnt_q != '0);
  assign quo_o  = q_q;

  // shift one bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= 7'd96;
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= num_i; r_q <= '0; d_q <= den_i;
    end else if (busy_o) begin
      r_q <= ge ? 64'(r_sh - {1'b0, d_q}) : r_sh[63:0];
      q_q <= {q_q[94:0], ge};
    end
  end
endmodule
`default_nettype wire

@@ src/vnorm_sqrt.sv @@
// Iterative integer square root of a 64-bit value, one result bit per cycle.
// No dependencies.
`default_nettype none
module vnorm_sqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] x_i,
  output logic             busy_o,
  output logic [31:0]      root_o
);
  logic [63:0] x_q;
  logic [63:0] rem_q;
  logic [31:0] root_q;
  logic [5:0]  cnt_q;
  logic [65:0] rem_sh, trial;

  assign rem_sh = {rem_q, x_q[63:62]};
  assign trial  = {32'd0, root_q, 2'b01};
  assign busy_o = (cnt_q != '0);
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (start_i) cnt_q <= 6'd32;
    else if (busy_o) cnt_q <= cnt_q - 1'b1;
  end

  // two radicand bits per step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i; rem_q <= '0; root_q <= '0;
    end else if (busy_o) begin
      x_q <= {x_q[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q <= 64'(rem_sh - trial); root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh[63:0]; root_q <= {root_q[30:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

@@ src/vnorm_dp.sv @@
// Datapath: sample store, reductions, shared divider, square root, output.
// Depends on vnorm_pkg, vnorm_div, vnorm_sqrt.
`default_nettype none
module vnorm_dp (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [31:0]            sample_i,
  input  wire logic                   wr_i,
  input  wire logic [2:0]             mode_i,
  input  wire vnorm_pkg::dp_cmd_t     cmd_i,
  input  wire logic [vnorm_pkg::AddrW-1:0] raddr_i,
  input  wire logic [vnorm_pkg::CntW-1:0]  fill_i,
  input  wire logic                   emit_i,
  input  wire logic                   emit_last_i,
  input  wire logic                   drop_i,
  input  wire logic                   out_taken_i,
  output vnorm_pkg::dp_sts_t          sts_o,
  output logic                        out_valid_o,
  output logic [31:0]                 out_value_o,
  output logic                        out_last_o,
  output logic                        out_sat_o,
  output logic                        out_ovf_o
);
  logic [31:0] mem_q [vnorm_pkg::Depth];
  logic [31:0] rd_q;
  logic signed [39:0] sum_q;
  logic signed [31:0] lo_q, hi_q;
  logic signed [32:0] mean_q;
  logic [63:0] acc_lo_q;
  logic [7:0]  acc_hi_q;
  logic signed [39:0] den_q;
  logic signed [33:0] base_q;
  logic act_q;
  logic [33:0] dev_mag;
  logic signed [33:0] dev;
  logic [67:0] sq;

  logic        dstart;
  logic [95:0] dnum, dquo;
  logic [63:0] dden;
  logic        dbusy, sbusy;
  logic [31:0] root;
  logic        first_q;

  // store write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[fill_i[vnorm_pkg::AddrW-1:0]] <= sample_i;
    if (cmd_i.rd_en) rd_q <= mem_q[raddr_i];
  end

  assign dev = 34'(signed'(rd_q)) - 34'(mean_q);
  assign dev_mag = dev[33] ? 34'(-dev) : 34'(dev);
  assign sq = dev_mag * dev_mag;

  // reductions and variance accumulation
  always_ff @(posedge clk_i) begin
    if (cmd_i.red_clr) begin
      sum_q <= '0; first_q <= 1'b1; acc_lo_q <= '0; acc_hi_q <= '0;
    end else if (cmd_i.red_step) begin
      sum_q <= sum_q + 40'(signed'(rd_q));
      first_q <= 1'b0;
      if (first_q || signed'(rd_q) < lo_q) lo_q <= rd_q;
      if (first_q || signed'(rd_q) > hi_q) hi_q <= rd_q;
    end else if (cmd_i.var_step) begin
      {acc_hi_q, acc_lo_q} <= {acc_hi_q, acc_lo_q} + 72'(sq);
    end
  end

  // shared divider operand select
  logic [39:0] sum_mag;
  logic signed [34:0] snum;
  logic [34:0] snum_mag;
  assign sum_mag  = sum_q[39] ? 40'(-sum_q) : 40'(sum_q);
  assign snum     = 35'(signed'(rd_q)) - 35'(base_q);
  assign snum_mag = snum[34] ? 35'(-snum) : 35'(snum);
  assign dstart   = cmd_i.mean_go || cmd_i.vdiv_go || cmd_i.div_go;

  always_comb begin
    dnum = '0; dden = 64'(fill_i);
    if (cmd_i.mean_go) dnum = 96'(sum_mag);
    else if (cmd_i.vdiv_go) dnum = {24'd0, acc_hi_q, acc_lo_q};
    else begin
      dnum = 96'(snum_mag) << vnorm_pkg::FracBits;
      dden = den_q[39] ? 64'(-den_q) : 64'(den_q);
    end
  end

  vnorm_div u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(dden),
    .busy_o(dbusy), .quo_o(dquo)
  );

  // mean lands once the divider finishes
  logic mean_pend_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_pend_q <= 1'b0;
    end else begin
      if (cmd_i.mean_go) mean_pend_q <= 1'b1;
      else if (!dbusy) mean_pend_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (mean_pend_q && !dbusy)
      mean_q <= sum_q[39] ? -33'(dquo[32:0]) : 33'(dquo[32:0]);
  end

  vnorm_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(cmd_i.sqrt_go), .x_i(dquo[63:0]),
    .busy_o(sbusy), .root_o(root)
  );

  // divisor and base per mode
  always_ff @(posedge clk_i) begin
    if (cmd_i.pick) begin
      base_q <= '0; den_q <= '0;
      case (mode_i)
        vnorm_pkg::MODE_SUM: den_q <= sum_q;
        vnorm_pkg::MODE_MAX: den_q <= 40'(hi_q);
        vnorm_pkg::MODE_MIN: den_q <= 40'(lo_q);
        vnorm_pkg::MODE_RNG: begin
          den_q <= 40'(hi_q) - 40'(lo_q); base_q <= 34'(lo_q);
        end
        vnorm_pkg::MODE_ZSC: begin
          den_q <= (fill_i >= 2) ? 40'(root) : '0; base_q <= 34'(mean_q);
        end
        default: den_q <= '0;
      endcase
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) act_q <= 1'b0;
    else if (cmd_i.pick) act_q <= 1'b1;
    else act_q <= act_q;
  end
  logic active;
  assign active = act_q && (den_q != '0);

  assign sts_o.div_busy  = dbusy;
  assign sts_o.sqrt_busy = sbusy;
  assign sts_o.active    = active;

  // signed saturating result
  logic neg;
  logic [31:0] rval;
  logic rsat;
  assign neg = snum[34] ^ den_q[39];
  always_comb begin
    rsat = 1'b0; rval = rd_q;
    if (active) begin
      if (!neg) begin
        if (dquo > 96'h7FFF_FFFF) begin rsat = 1'b1; rval = 32'h7FFF_FFFF; end
        else rval = dquo[31:0];
      end else begin
        if (dquo > 96'h8000_0000) begin rsat = 1'b1; rval = 32'h8000_0000; end
        else rval = 32'(-dquo[31:0]);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (emit_i) out_valid_o <= 1'b1;
    else if (out_taken_i) out_valid_o <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (emit_i) begin
      out_value_o <= rval; out_last_o <= emit_last_i;
      out_sat_o <= rsat; out_ovf_o <= drop_i;
    end
  end
endmodule
`default_nettype wire

@@ src/vector_normalization_core.sv @@
// Vector normalization core: a set of signed Q16.16 samples on the slave
// stream, closed by tlast, is stored and then emitted normalized on the
// master stream. tdata carries the sample; tlast ends the set.
// Master tdata: value; tuser: {overflow, saturated}; tlast ends the set.
// Mode register at APB address 0: 0 sum, 1 max, 2 min, 3 range, 4 z-score.
// Input is accepted only while loading; a set of n samples is first reduced
// (for z-score, then a variance pass, a division and a square root), then
// each sample is divided in turn by the one-bit-per-cycle shared divider
// (no division when the divisor is zero: the sample passes through).
// Samples beyond 64 are dropped and flagged. A stalled master holds the
// output register and the core waits. Reset clears mode, counts and flags;
// the store needs no clearing.
// Depends on vnorm_pkg, vnorm_ctrl, vnorm_dp.
`default_nettype none
module vector_normalization_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // sample
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // value
  output logic             m_axis_tlast,
  output logic [1:0]       m_axis_tuser,   // [0] saturated, [1] overflow
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [2:0] mode_q;
  logic [vnorm_pkg::CntW-1:0] fill_q;
  logic drop_q;
  logic in_fire, load, emit, emit_last, done;
  vnorm_pkg::dp_cmd_t cmd;
  vnorm_pkg::dp_sts_t sts;
  logic [vnorm_pkg::AddrW-1:0] raddr;
  logic full, wr;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {29'd0, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= '0;
    else if (psel && penable && pwrite && paddr == 2'd0) mode_q <= pwdata[2:0];
  end

  assign s_axis_tready = load;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign full = (fill_q == vnorm_pkg::CntW'(vnorm_pkg::Depth));
  assign wr = in_fire && !full;

  // fill count and drop flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0; drop_q <= 1'b0;
    end else if (done) begin
      fill_q <= '0; drop_q <= 1'b0;
    end else if (in_fire) begin
      if (full) drop_q <= 1'b1;
      else fill_q <= fill_q + 1'b1;
    end
  end

  vnorm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .in_last_i(s_axis_tlast),
    .mode_i(mode_q), .fill_i(fill_q), .sts_i(sts),
    .out_free_i(!m_axis_tvalid || m_axis_tready),
    .cmd_o(cmd), .raddr_o(raddr), .load_o(load), .emit_o(emit),
    .emit_last_o(emit_last), .done_o(done)
  );

  vnorm_dp u_dp (
    .clk_i, .rst_ni, .sample_i(s_axis_tdata), .wr_i(wr), .mode_i(mode_q),
    .cmd_i(cmd), .raddr_i(raddr), .fill_i(fill_q), .emit_i(emit),
    .emit_last_i(emit_last), .drop_i(drop_q),
    .out_taken_i(m_axis_tready), .sts_o(sts),
    .out_valid_o(m_axis_tvalid), .out_value_o(m_axis_tdata),
    .out_last_o(m_axis_tlast), .out_sat_o(m_axis_tuser[0]),
    .out_ovf_o(m_axis_tuser[1])
  );
endmodule
`default_nettype wire

@@ src/vnorm_checker.sv @@
// Port-level checker for the vector normalization core, bound to the top.
// No dependencies.
`default_nettype none
module vnorm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        pready
);
  // hold a stalled transfer and its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output dropped while stalled");
  // hold the side fields of a stalled transfer
  a_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable({m_axis_tlast, m_axis_tuser}))
    else $error("side fields changed while stalled");
  // keep handshakes known out of reset
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({s_axis_tready, m_axis_tvalid}))
    else $error("handshake unknown");
  a_pr: assert property (@(posedge clk_i) pready)
    else $error("pready low");
endmodule
bind vector_normalization_core vnorm_checker u_chk (.*);
`default_nettype wire
